@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Sizes, request and result payloads, memory port bundle, opcodes, status
// codes and sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Storage size and field widths.
  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int PRIO_BITS = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Action codes. Query size and the unused codes share the default path.
  localparam logic [2:0] ACT_ENQ  = 3'd0;
  localparam logic [2:0] ACT_DEQ  = 3'd1;
  localparam logic [2:0] ACT_PEEK = 3'd2;
  localparam logic [2:0] ACT_LIST = 3'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // Input request payload.
  typedef struct packed {
    logic [2:0]           action;
    logic [PRIO_BITS-1:0] priority_req;
    logic [DATA_BITS-1:0] data_in;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [1:0]           status;
    logic [DATA_BITS-1:0] data_out;
    logic [PRIO_BITS-1:0] priority_out;
    logic [CNT_W-1:0]     count;
    logic                 empty_res;
    logic                 last;
  } res_t;

  // One stored entry.
  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  // Access bundle from the sequencer to the entry memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_HEAD_RD,
    ST_HEAD_USE,
    ST_DOWN_RD,
    ST_DOWN_WR,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_t;

endpackage

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-list priority queue
// Holds up to DEPTH entries, highest priority at the head, in a small
// memory walked by a small sequencer.
// ----------------------------------------------------------------------------
// Start high with busy low takes a request; if it leaves idle, busy stays high
// until the request is done. Every result appears on out_res for exactly one
// cycle with out_valid high, one cycle after the sequencer produces it, and
// must be captured then: the receiver cannot hold results off. Each entry
// visited costs one memory read and then one compare or write, since
// the memory has a single registered read port. Size queries and dequeue,
// peek or list on an empty queue are answered from idle; enqueue scans to
// the insert point, moves the entries below it up one place and writes the
// new entry; a duplicate or a full queue ends the enqueue after the scan;
// dequeue reads the head and moves the rest down; peek reads the head; a
// list run gives one result per entry, head first.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t in_req,
  output logic          out_valid,
  output spq_pkg::res_t out_res
);

  spq_pkg::mem_req_t mem_req;
  spq_pkg::entry_t   mem_rdata;
  logic              res_valid;
  spq_pkg::res_t     res;
  logic              out_valid_r;
  spq_pkg::res_t     out_res_r;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req_i       (in_req),
    .busy        (busy),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  spq_mem u_mem (
    .clk     (clk),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result strobe register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ sv/spq_mem.sv @@
// ----------------------------------------------------------------------------
// spq_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem (
  input  logic              clk,
  input  spq_pkg::mem_req_t mem_i,
  output spq_pkg::entry_t   rdata_o
);

  spq_pkg::entry_t mem_r [spq_pkg::DEPTH];
  spq_pkg::entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_i.we) begin
      mem_r[mem_i.waddr] <= mem_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[mem_i.raddr];
  end

  assign rdata_o = rdata_r;

endmodule

@@ sv/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl: queue sequencer
// Walks the entry memory one entry at a time with a single priority
// comparator: scan for the insert point, shift entries up or down, and
// read out the list. Holds the entry count.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  spq_pkg::req_t     req_i,
  output logic              busy,
  output spq_pkg::mem_req_t mem_o,
  input  spq_pkg::entry_t   rdata_i,
  output logic              res_valid_o,
  output spq_pkg::res_t     res_o
);

  spq_pkg::state_t                 state_r, state_nxt;
  logic [spq_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [spq_pkg::IDX_W-1:0]       pos_r, pos_nxt;
  logic [spq_pkg::CNT_W-1:0]       count_r, count_nxt;
  spq_pkg::entry_t                 new_r, new_nxt;
  spq_pkg::entry_t                 head_r, head_nxt;
  logic                            peek_r, peek_nxt;

  logic                            prio_eq;
  logic                            prio_gt;
  logic                            idx_is_last;
  logic [1:0]                      res_status;
  spq_pkg::entry_t                 res_entry;
  logic                            res_last;

  // Shared comparator between the new priority and the entry just read.
  assign prio_eq     = new_r.prio == rdata_i.prio;
  assign prio_gt     = new_r.prio > rdata_i.prio;
  assign idx_is_last = (spq_pkg::CNT_W'(idx_r) + spq_pkg::CNT_W'(1)) == count_r;

  assign busy = state_r != spq_pkg::ST_IDLE;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    new_r  <= new_nxt;
    head_r <= head_nxt;
    peek_r <= peek_nxt;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    new_nxt     = new_r;
    head_nxt    = head_r;
    peek_nxt    = peek_r;
    mem_o       = '0;
    res_valid_o = 1'b0;
    res_status  = spq_pkg::STAT_OK;
    res_entry   = '0;
    res_last    = 1'b0;

    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        if (start) begin
          new_nxt.prio = req_i.priority_req;
          new_nxt.data = req_i.data_in;
          idx_nxt      = '0;
          peek_nxt     = req_i.action == spq_pkg::ACT_PEEK;
          case (req_i.action) inside
            spq_pkg::ACT_ENQ: begin
              if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = spq_pkg::ST_INSERT;
              end else begin
                state_nxt = spq_pkg::ST_SCAN_RD;
              end
            end
            spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK: begin
              if (count_r == '0) begin
                res_valid_o = 1'b1;
                res_status  = spq_pkg::STAT_EMPTY;
              end else begin
                state_nxt = spq_pkg::ST_HEAD_RD;
              end
            end
            spq_pkg::ACT_LIST: begin
              if (count_r == '0) begin
                res_valid_o = 1'b1;
                res_status  = spq_pkg::STAT_EMPTY;
                res_last    = 1'b1;
              end else begin
                state_nxt = spq_pkg::ST_LIST_RD;
              end
            end
            default: begin
              // Size query and unused codes report the count only.
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      // Scan from the head for the first entry not above the new priority.
      spq_pkg::ST_SCAN_RD: begin
        mem_o.raddr = idx_r;
        state_nxt   = spq_pkg::ST_SCAN_CMP;
      end

      spq_pkg::ST_SCAN_CMP: begin
        if (prio_eq) begin
          res_valid_o = 1'b1;
          res_status  = spq_pkg::STAT_DUP;
          state_nxt   = spq_pkg::ST_IDLE;
        end else if (prio_gt || idx_is_last) begin
          if (count_r == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
            res_valid_o = 1'b1;
            res_status  = spq_pkg::STAT_FULL;
            state_nxt   = spq_pkg::ST_IDLE;
          end else if (prio_gt) begin
            // Open a slot at idx by moving the tail up one place.
            pos_nxt   = idx_r;
            idx_nxt   = count_r[spq_pkg::IDX_W-1:0];
            state_nxt = spq_pkg::ST_SHIFT_RD;
          end else begin
            pos_nxt   = count_r[spq_pkg::IDX_W-1:0];
            state_nxt = spq_pkg::ST_INSERT;
          end
        end else begin
          idx_nxt   = idx_r + spq_pkg::IDX_W'(1);
          state_nxt = spq_pkg::ST_SCAN_RD;
        end
      end

      // Move entry idx-1 to idx, from the tail down to the insert point.
      spq_pkg::ST_SHIFT_RD: begin
        mem_o.raddr = idx_r - spq_pkg::IDX_W'(1);
        state_nxt   = spq_pkg::ST_SHIFT_WR;
      end

      spq_pkg::ST_SHIFT_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_r;
        mem_o.wdata = rdata_i;
        idx_nxt     = idx_r - spq_pkg::IDX_W'(1);
        if ((idx_r - spq_pkg::IDX_W'(1)) == pos_r) begin
          state_nxt = spq_pkg::ST_INSERT;
        end else begin
          state_nxt = spq_pkg::ST_SHIFT_RD;
        end
      end

      spq_pkg::ST_INSERT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_r;
        mem_o.wdata = new_r;
        count_nxt   = count_r + spq_pkg::CNT_W'(1);
        res_valid_o = 1'b1;
        state_nxt   = spq_pkg::ST_IDLE;
      end

      // Head read for dequeue and peek.
      spq_pkg::ST_HEAD_RD: begin
        mem_o.raddr = '0;
        state_nxt   = spq_pkg::ST_HEAD_USE;
      end

      spq_pkg::ST_HEAD_USE: begin
        head_nxt = rdata_i;
        if (peek_r) begin
          res_valid_o = 1'b1;
          res_entry   = rdata_i;
          state_nxt   = spq_pkg::ST_IDLE;
        end else if (count_r == spq_pkg::CNT_W'(1)) begin
          count_nxt   = '0;
          res_valid_o = 1'b1;
          res_entry   = rdata_i;
          state_nxt   = spq_pkg::ST_IDLE;
        end else begin
          idx_nxt   = spq_pkg::IDX_W'(1);
          state_nxt = spq_pkg::ST_DOWN_RD;
        end
      end

      // Move entry idx to idx-1 until the tail has closed the gap.
      spq_pkg::ST_DOWN_RD: begin
        mem_o.raddr = idx_r;
        state_nxt   = spq_pkg::ST_DOWN_WR;
      end

      spq_pkg::ST_DOWN_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_r - spq_pkg::IDX_W'(1);
        mem_o.wdata = rdata_i;
        if (idx_is_last) begin
          count_nxt   = count_r - spq_pkg::CNT_W'(1);
          res_valid_o = 1'b1;
          res_entry   = head_r;
          state_nxt   = spq_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + spq_pkg::IDX_W'(1);
          state_nxt = spq_pkg::ST_DOWN_RD;
        end
      end

      // List run: one result per entry, head first.
      spq_pkg::ST_LIST_RD: begin
        mem_o.raddr = idx_r;
        state_nxt   = spq_pkg::ST_LIST_OUT;
      end

      spq_pkg::ST_LIST_OUT: begin
        res_valid_o = 1'b1;
        res_entry   = rdata_i;
        res_last    = idx_is_last;
        if (idx_is_last) begin
          state_nxt = spq_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + spq_pkg::IDX_W'(1);
          state_nxt = spq_pkg::ST_LIST_RD;
        end
      end

      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase

    res_o.status       = res_status;
    res_o.data_out     = res_entry.data;
    res_o.priority_out = res_entry.prio;
    res_o.count        = count_nxt;
    res_o.empty_res    = count_nxt == '0;
    res_o.last         = res_last;
  end

endmodule
